FILE: rtl/core/banked_rom_mapper_scanline_irq_unit_macros.svh
// Assertion macros for the mapper RTL.
`ifndef BANKED_ROM_MAPPER_SCANLINE_IRQ_UNIT_MACROS_SVH
`define BANKED_ROM_MAPPER_SCANLINE_IRQ_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BRMSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRMSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/brmsi_pkg.sv
// Package for the banked ROM mapper: command codes, register decode and constants.
package brmsi_pkg;

    localparam int ROM_ADDR_BITS_DEFAULT = 21;
    localparam int BANK_COUNT_BITS       = 9;
    localparam int PRG_OFFSET_BITS       = 13;
    localparam int CHR_OFFSET_BITS       = 10;

    localparam logic [BANK_COUNT_BITS-1:0] PRG_BANK_COUNT_RESET = 9'd64;

    typedef enum logic [1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_SCANLINE  = 2'd1,
        CMD_PRG_LOOKUP = 2'd2,
        CMD_CHR_LOOKUP = 2'd3
    } cmd_t;

    // Register window selected by CPU address bits 14:13
    typedef enum logic [1:0] {
        REG_BANK     = 2'd0,
        REG_MIRROR   = 2'd1,
        REG_IRQ_LOAD = 2'd2,
        REG_IRQ_EN   = 2'd3
    } reg_region_t;

    typedef struct packed {
        logic [7:0]      bank_select;
        logic [7:0][7:0] bank_regs;
    } bank_state_t;

endpackage

FILE: rtl/core/brmsi_lookup.sv
// Address translation for program and pattern lookups.
module brmsi_lookup import brmsi_pkg::*; #(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEFAULT
) (
    input  cmd_t                       cmd,
    input  logic [15:0]                address,
    input  bank_state_t                banks,
    input  logic [BANK_COUNT_BITS-1:0] prg_bank_count,
    output logic [ROM_ADDR_BITS-1:0]   rom_address
);

    localparam int PRG_BW = ROM_ADDR_BITS - PRG_OFFSET_BITS;
    localparam int CHR_BW = ROM_ADDR_BITS - CHR_OFFSET_BITS;

    logic [PRG_BW-1:0] count_w;
    logic [PRG_BW-1:0] prg_bank;
    logic [2:0]        chr_win;
    logic [7:0]        chr_pair;
    logic [7:0]        chr_bank;
    logic [2:0]        chr_idx;

    always_comb begin
        // Fixed banks wrap modulo the bank field width
        count_w = PRG_BW'(prg_bank_count);
        unique case (address[14:13])
            2'd1: prg_bank = PRG_BW'(banks.bank_regs[7]);
            2'd3: prg_bank = count_w - PRG_BW'(1);
            2'd0: prg_bank = banks.bank_select[6] ? count_w - PRG_BW'(2)
                                                  : PRG_BW'(banks.bank_regs[6]);
            default: prg_bank = banks.bank_select[6] ? PRG_BW'(banks.bank_regs[6])
                                                     : count_w - PRG_BW'(2);
        endcase

        // Swap the 2 KB and 1 KB halves when bit 7 of bank select is set
        chr_win  = address[12:10] ^ {banks.bank_select[7], 2'b00};
        chr_pair = banks.bank_regs[{2'b00, chr_win[1]}];
        chr_idx  = chr_win - 3'd2;
        if (!chr_win[2]) begin
            chr_bank = chr_win[0] ? (chr_pair | 8'h01) : (chr_pair & 8'hfe);
        end else begin
            chr_bank = banks.bank_regs[chr_idx];
        end

        unique case (cmd)
            CMD_PRG_LOOKUP: rom_address = {prg_bank, address[PRG_OFFSET_BITS-1:0]};
            CMD_CHR_LOOKUP: rom_address = {CHR_BW'(chr_bank), address[CHR_OFFSET_BITS-1:0]};
            default:        rom_address = '0;
        endcase
    end

endmodule

FILE: rtl/core/banked_rom_mapper_scanline_irq_unit.sv
// Banked ROM mapper with scanline IRQ counter. Items enter through an input
// register, are decoded and translated in one pass, and leave through a result
// register, so the block takes one item every cycle; only a stalled result slot
// holds it back. State (bank registers, mirroring, RAM control, IRQ counter) is
// updated as each item moves into the result register, and the status outputs
// show it after that item. The bank count register may be written only while
// the block is idle.
`include "banked_rom_mapper_scanline_irq_unit_macros.svh"

module banked_rom_mapper_scanline_irq_unit import brmsi_pkg::*; #(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [BANK_COUNT_BITS-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [15:0]                s_address,
    input  logic [7:0]                 s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ROM_ADDR_BITS-1:0]   m_rom_address,
    output logic                       m_irq_line,
    output logic                       m_mirror_horizontal,
    output logic                       m_ram_enabled,
    output logic                       m_ram_write_protected
);

    logic                       in_valid_reg;
    cmd_t                       in_cmd_reg;
    logic [15:0]                in_addr_reg;
    logic [7:0]                 in_data_reg;
    logic                       out_valid_reg;
    logic [ROM_ADDR_BITS-1:0]   rom_reg;
    logic                       advance;

    logic [BANK_COUNT_BITS-1:0] prg_count_reg;
    logic [7:0]                 bank_select_reg, bank_select_next;
    logic [7:0][7:0]            bank_regs_reg, bank_regs_next;
    logic                       ram_en_reg, ram_en_next;
    logic                       ram_prot_reg, ram_prot_next;
    logic                       mirror_reg, mirror_next;
    logic [7:0]                 latch_reg, latch_next;
    logic [7:0]                 count_reg, count_next;
    logic                       irq_en_reg, irq_en_next;
    logic                       reload_reg, reload_next;
    logic                       irq_reg, irq_next;

    logic [7:0]                 tick_start;
    logic [7:0]                 tick_dec;
    bank_state_t                banks;
    logic [ROM_ADDR_BITS-1:0]   rom_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_cmd_reg  <= cmd_t'(s_command);
            in_addr_reg <= s_address;
            in_data_reg <= s_data;
        end
    end

    assign banks = {bank_select_reg, bank_regs_reg};

    brmsi_lookup #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_lookup (
        .cmd            (in_cmd_reg),
        .address        (in_addr_reg),
        .banks          (banks),
        .prg_bank_count (prg_count_reg),
        .rom_address    (rom_next)
    );

    always_comb begin
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        ram_en_next      = ram_en_reg;
        ram_prot_next    = ram_prot_reg;
        mirror_next      = mirror_reg;
        latch_next       = latch_reg;
        count_next       = count_reg;
        irq_en_next      = irq_en_reg;
        reload_next      = reload_reg;
        irq_next         = irq_reg;

        tick_start = reload_reg ? latch_reg : count_reg;
        tick_dec   = (tick_start != 8'd0) ? tick_start - 8'd1 : 8'd0;

        unique case (in_cmd_reg)
            CMD_REG_WRITE: begin
                // Ignore writes below the cartridge register window
                if (in_addr_reg[15]) begin
                    unique case (reg_region_t'(in_addr_reg[14:13]))
                        REG_BANK: begin
                            if (in_addr_reg[0]) begin
                                bank_regs_next[bank_select_reg[2:0]] = in_data_reg;
                            end else begin
                                bank_select_next = in_data_reg;
                            end
                        end
                        REG_MIRROR: begin
                            if (in_addr_reg[0]) begin
                                ram_en_next   = in_data_reg[7];
                                ram_prot_next = in_data_reg[6];
                            end else begin
                                mirror_next = in_data_reg[0];
                            end
                        end
                        REG_IRQ_LOAD: begin
                            if (in_addr_reg[0]) begin
                                latch_next  = in_data_reg;
                                reload_next = 1'b1;
                            end else begin
                                count_next = latch_reg;
                            end
                        end
                        REG_IRQ_EN: begin
                            irq_en_next = in_addr_reg[0];
                        end
                        default: ;
                    endcase
                end
            end
            CMD_SCANLINE: begin
                reload_next = 1'b0;
                if (tick_dec == 8'd0) begin
                    irq_next   = irq_en_reg;
                    count_next = latch_reg;
                end else begin
                    count_next = tick_dec;
                end
            end
            default: ;
        endcase
    end

    // Mapper state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            prg_count_reg   <= PRG_BANK_COUNT_RESET;
            bank_select_reg <= '0;
            bank_regs_reg   <= '0;
            ram_en_reg      <= 1'b1;
            ram_prot_reg    <= 1'b1;
            mirror_reg      <= 1'b0;
            latch_reg       <= '0;
            count_reg       <= '0;
            irq_en_reg      <= 1'b0;
            reload_reg      <= 1'b0;
            irq_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                prg_count_reg <= cfg_wr_data;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                bank_select_reg <= bank_select_next;
                bank_regs_reg   <= bank_regs_next;
                ram_en_reg      <= ram_en_next;
                ram_prot_reg    <= ram_prot_next;
                mirror_reg      <= mirror_next;
                latch_reg       <= latch_next;
                count_reg       <= count_next;
                irq_en_reg      <= irq_en_next;
                reload_reg      <= reload_next;
                irq_reg         <= irq_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            rom_reg <= rom_next;
        end
    end

    // Status outputs follow state, which only moves with the result slot
    assign m_valid               = out_valid_reg;
    assign m_rom_address         = rom_reg;
    assign m_irq_line            = irq_reg;
    assign m_mirror_horizontal   = mirror_reg;
    assign m_ram_enabled         = ram_en_reg;
    assign m_ram_write_protected = ram_prot_reg;

    `BRMSI_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, s_ready,
        "input register empty but not ready")
    `BRMSI_ASSERT_NEXT(a_result_follows, advance, m_valid,
        "advanced item did not reach the result register")
    `BRMSI_ASSERT_NEXT(a_irq_only_on_tick, !(advance && in_cmd_reg == CMD_SCANLINE),
        $stable(irq_reg), "irq line moved without a scanline tick")
    `BRMSI_ASSERT_NEXT(a_ram_only_on_write, !(advance && in_cmd_reg == CMD_REG_WRITE),
        $stable(ram_en_reg) && $stable(ram_prot_reg),
        "RAM control moved without a register write")

endmodule
